// File: hdl/rpa_pkg.sv
package rpa_pkg;

    localparam int NUM_BINS   = 1024;
    localparam int BIN_BITS   = 10;
    localparam int COORD_BITS = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_MAX  = 3'd6;

    localparam logic OP_VOXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [29:0] COUNT_MAX  = 30'h3FFF_FFFF;
    localparam logic [18:0] RADIUS_MAX = 19'h7FFFF;

    typedef struct packed {
        logic                   op;
        logic [COORD_BITS-1:0]  pos_x;
        logic [COORD_BITS-1:0]  pos_y;
        logic [COORD_BITS-1:0]  pos_z;
        logic signed [15:0]     voxel_value;
        logic [9:0]             bin_index;
    } t_in_item;

    typedef struct packed {
        logic [18:0]        bin_radius;
        logic [29:0]        voxel_count;
        logic signed [15:0] mean_value;
        logic [15:0]        std_value;
    } t_out_item;

    // Classified command passed from front to back through the queue
    typedef struct packed {
        logic                is_read;
        logic                keep;      // voxel passed range checks
        logic [BIN_BITS-1:0] bin;
        logic signed [15:0]  value;
        logic [18:0]         radius;    // saturated radius for reads
    } t_cmd;

    typedef struct packed {
        logic [17:0] center_x;
        logic [17:0] center_y;
        logic [17:0] center_z;
        logic [15:0] bin_step;
        logic [15:0] inv_step;
        logic [18:0] rad_min;
        logic [18:0] rad_max;
    } t_cfg;

endpackage

// File: hdl/rpa_stream_if.sv
interface rpa_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/radial_profile_accumulator_unit.sv
// Radial intensity profile accumulator. Voxel transactions (op 0) are
// binned by rounded distance from a configured Q10.8 centre into 1024
// bins of count, sum and sum of squares; read transactions (op 1) return
// a bin's radius, count, mean and sample standard deviation and clear it.
// After reset all 1024 bins of the store are swept clear; meanwhile the
// front and queue take up to three transactions, which the back starts
// once the sweep is done. A voxel occupies the front from one accept to
// the next (three squaring steps, a 20-step root, binning, range test,
// hand-over), so the front takes no new item until it has handed on the
// last; a read's time in the back is set by two 128-step divisions and a root.
// A two-entry queue lets the front classify the next transaction while
// the back works and while a result waits to be taken.
module radial_profile_accumulator_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rpa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    rpa_stream_if.sink                        s_in,
    rpa_stream_if.source                      m_out
);
    import rpa_pkg::*;

    t_cfg r_cfg;
    logic f_valid, f_ready, b_valid, b_ready;
    t_cmd f_cmd, b_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x <= '0;
            r_cfg.center_y <= '0;
            r_cfg.center_z <= '0;
            r_cfg.bin_step <= 16'd26;
            r_cfg.inv_step <= 16'd2560;
            r_cfg.rad_min  <= '0;
            r_cfg.rad_max  <= RADIUS_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X: r_cfg.center_x <= i_cfg_data[17:0];
                REG_CENTER_Y: r_cfg.center_y <= i_cfg_data[17:0];
                REG_CENTER_Z: r_cfg.center_z <= i_cfg_data[17:0];
                REG_BIN_STEP: r_cfg.bin_step <= i_cfg_data[15:0];
                REG_INV_STEP: r_cfg.inv_step <= i_cfg_data[15:0];
                REG_RAD_MIN:  r_cfg.rad_min  <= i_cfg_data;
                REG_RAD_MAX:  r_cfg.rad_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rpa_front u_front (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(s_in.valid), .o_ready(s_in.ready), .i_item(s_in.data),
        .o_cmd_valid(f_valid), .i_cmd_ready(f_ready), .o_cmd(f_cmd)
    );

    rpa_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_cmd(f_cmd),
        .o_valid(b_valid), .i_ready(b_ready), .o_cmd(b_cmd)
    );

    rpa_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_valid), .o_ready(b_ready), .i_cmd(b_cmd),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_item(m_out.data)
    );
endmodule

// File: hdl/rpa_front.sv
// Command classifier: voxel distance, bin index and range test, or read radius. One item at a time.
module rpa_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rpa_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  rpa_pkg::t_in_item i_item,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output rpa_pkg::t_cmd   o_cmd
);
    import rpa_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_SQ, S_SQRT, S_BIN, S_CHK, S_RNG, S_OUT} t_state;

    t_state       r_state;
    t_in_item     r_item;
    logic [1:0]   r_axis;
    logic [39:0]  r_d2;
    logic [39:0]  r_rem;
    logic [20:0]  r_root;
    logic [4:0]   r_it;
    logic [36:0]  r_kprod;
    logic [35:0]  r_rprod;
    t_cmd         r_cmd;

    logic signed [19:0] w_delta;
    logic [17:0]        w_c;
    logic [COORD_BITS+7:0] w_p;
    logic [19:0]        w_mag;
    logic [41:0]        w_trial;
    logic [20:0]        w_k;

    always_comb begin
        case (r_axis)
            2'd0:    begin w_p = {r_item.pos_x, 8'd0}; w_c = i_cfg.center_x; end
            2'd1:    begin w_p = {r_item.pos_y, 8'd0}; w_c = i_cfg.center_y; end
            default: begin w_p = {r_item.pos_z, 8'd0}; w_c = i_cfg.center_z; end
        endcase
        w_delta = $signed({2'b00, w_p}) - $signed({2'b00, w_c});
        w_mag   = w_delta[19] ? 20'(-w_delta) : 20'(w_delta);
        w_trial = {r_rem, r_d2[39:38]} - {19'd0, r_root, 2'b01};
        w_k     = r_kprod[36:16];
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_cmd_valid = (r_state == S_OUT);
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_item;
                        r_axis <= 2'd0;
                        r_d2   <= '0;
                        r_state <= (i_item.op == OP_READ) ? S_CHK : S_SQ;
                        r_rprod <= 36'(i_item.bin_index) * 36'(i_cfg.bin_step);
                    end
                end
                S_SQ: begin
                    r_d2 <= r_d2 + 40'(w_mag) * 40'(w_mag);
                    if (r_axis == 2'd2) begin
                        r_state <= S_SQRT;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_it    <= '0;
                    end
                    r_axis <= r_axis + 2'd1;
                end
                S_SQRT: begin
                    // restoring square root, one result bit a cycle
                    if (!w_trial[41]) begin
                        r_rem  <= w_trial[39:0];
                        r_root <= {r_root[19:0], 1'b1};
                    end else begin
                        r_rem  <= {r_rem[37:0], r_d2[39:38]};
                        r_root <= {r_root[19:0], 1'b0};
                    end
                    r_d2 <= {r_d2[37:0], 2'b00};
                    r_it <= r_it + 5'd1;
                    if (r_it == 5'd19) r_state <= S_BIN;
                end
                S_BIN: begin
                    r_kprod <= 37'(r_root) * 37'(i_cfg.inv_step) + 37'd32768;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_item.op == OP_READ) begin
                        r_cmd.is_read <= 1'b1;
                        r_cmd.keep    <= 1'b1;
                        r_cmd.bin     <= r_item.bin_index;
                        r_cmd.radius  <= (r_rprod > 36'(RADIUS_MAX)) ? RADIUS_MAX
                                                                    : r_rprod[18:0];
                        r_cmd.value   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_rprod <= 36'(w_k[BIN_BITS-1:0]) * 36'(i_cfg.bin_step);
                        r_cmd.keep <= (w_k < 21'(NUM_BINS));
                        r_cmd.bin  <= w_k[BIN_BITS-1:0];
                        r_cmd.is_read <= 1'b0;
                        r_cmd.value <= r_item.voxel_value;
                        r_cmd.radius <= '0;
                        r_state <= S_RNG;
                    end
                end
                S_RNG: begin
                    // range test on the bin's radius (bin index times bin step)
                    r_cmd.keep <= r_cmd.keep && (r_rprod >= 36'(i_cfg.rad_min))
                                  && (r_rprod <= 36'(i_cfg.rad_max));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_cmd_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/rpa_queue.sv
// Two-entry command queue between front and back.
module rpa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rpa_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output rpa_pkg::t_cmd o_cmd
);
    import rpa_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

// File: hdl/rpa_back.sv
// Bin store and read-out: clearing sweep, read-modify-write, mean and
// standard deviation through a shared bit-serial divider and square root.
module rpa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rpa_pkg::t_cmd     i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output rpa_pkg::t_out_item o_item
);
    import rpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD, S_UPD, S_M1, S_M2, S_M3, S_V1, S_V2,
        S_DIVM, S_DIVV, S_SQRT, S_SD, S_OUT
    } t_state;

    logic [136:0] r_mem [NUM_BINS];   // {count, sum, sqsum}
    logic [136:0] r_rd;

    t_state               r_state;
    logic [BIN_BITS:0]    r_clr;
    t_cmd                 r_cmd;
    logic [29:0]          r_n;
    logic [46:0]          r_mag;
    logic                 r_neg;
    logic [59:0]          r_sq;
    logic [59:0]          r_nn1;
    logic [127:0]         r_num;
    logic [127:0]         r_acc;
    logic [63:0]          r_b;
    logic [63:0]          r_rem;
    logic [63:0]          r_q;
    logic [6:0]           r_i;
    logic [1:0]           r_part;
    logic [63:0]          r_root;
    t_out_item            r_out;

    logic [29:0]          w_n;
    logic signed [46:0]   w_s;
    logic [59:0]          w_sq;
    logic [64:0]          w_rem2;
    logic [64:0]          w_sub;
    logic [66:0]          w_strial;

    assign w_n  = r_rd[136:107];
    assign w_s  = r_rd[106:60];
    assign w_sq = r_rd[59:0];
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_item  = r_out;

    always_comb begin
        w_rem2   = {r_rem, r_num[127]};
        w_sub    = w_rem2 - {1'b0, r_b};
        w_strial = {r_rem, r_q[63:62]} - {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) r_mem[r_clr[BIN_BITS-1:0]] <= '0;
        if (r_state == S_IDLE && i_valid) r_rd <= r_mem[i_cmd.bin];
        if (r_state == S_UPD && !r_cmd.is_read && r_cmd.keep && w_n != COUNT_MAX)
            r_mem[r_cmd.bin] <= {w_n + 30'd1,
                                 47'(w_s + 47'(r_cmd.value)),
                                 60'(w_sq + 60'(32'(r_cmd.value) * 32'(r_cmd.value)))};
        if (r_state == S_UPD && r_cmd.is_read) r_mem[r_cmd.bin] <= '0;

        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr[BIN_BITS-1:0] == BIN_BITS'(NUM_BINS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    if (!r_cmd.is_read) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_n   <= w_n;
                        r_neg <= w_s[46];
                        r_mag <= w_s[46] ? 47'(-w_s) : 47'(w_s);
                        r_sq  <= w_sq;
                        r_out.bin_radius  <= r_cmd.radius;
                        r_out.voxel_count <= w_n;
                        r_out.mean_value  <= '0;
                        r_out.std_value   <= '0;
                        r_state <= (w_n == 30'd0) ? S_OUT : S_M1;
                    end
                end
                S_M1: begin
                    // mean: (mag + n/2) / n
                    r_num <= {81'd0, 47'(r_mag + 47'(r_n >> 1))};
                    r_b   <= 64'(r_n);
                    r_rem <= '0; r_q <= '0; r_i <= '0;
                    r_state <= S_DIVM;
                end
                S_DIVM: begin
                    if (!w_sub[64]) begin
                        r_rem <= w_sub[63:0]; r_q <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[63:0]; r_q <= {r_q[62:0], 1'b0};
                    end
                    r_num <= {r_num[126:0], 1'b0};
                    r_i <= r_i + 7'd1;
                    if (r_i == 7'd127) r_state <= S_M2;
                end
                S_M2: begin
                    if (r_neg)
                        r_out.mean_value <= (r_q > 64'd32768) ? 16'sh8000
                                            : 16'(-r_q[15:0]);
                    else
                        r_out.mean_value <= (r_q > 64'd32767) ? 16'sh7FFF : r_q[15:0];
                    r_acc  <= '0;
                    r_part <= 2'd0;
                    r_nn1  <= 60'(r_n) * 60'(r_n - 30'd1);
                    r_state <= (r_n > 30'd1) ? S_M3 : S_OUT;
                end
                S_M3: begin
                    // n*sq in two 30x30 partial products
                    if (r_part == 2'd0) begin
                        r_acc  <= 128'(60'(r_n) * 60'(r_sq[29:0]));
                        r_part <= 2'd1;
                    end else begin
                        r_acc  <= r_acc + (128'(60'(r_n) * 60'(r_sq[59:30])) << 30);
                        r_part <= 2'd0;
                        r_state <= S_V1;
                    end
                end
                S_V1: begin
                    // mag^2 in partial products (24-bit low, 23-bit high part), subtracted in S_V2
                    case (r_part)
                        2'd0: r_num <= 128'(48'(r_mag[23:0]) * 48'(r_mag[23:0]));
                        2'd1: r_num <= r_num
                                     + (128'(47'(r_mag[46:24]) * 47'(r_mag[23:0])) << 25);
                        default: r_num <= r_num
                                     + (128'(46'(r_mag[46:24]) * 46'(r_mag[46:24])) << 48);
                    endcase
                    r_part <= r_part + 2'd1;
                    if (r_part == 2'd2) r_state <= S_V2;
                end
                S_V2: begin
                    r_num <= (r_acc >= r_num) ? r_acc - r_num : 128'd0;
                    r_b   <= 64'(r_nn1);
                    r_rem <= '0; r_q <= '0; r_i <= '0;
                    r_state <= S_DIVV;
                end
                S_DIVV: begin
                    if (!w_sub[64]) begin
                        r_rem <= w_sub[63:0]; r_q <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[63:0]; r_q <= {r_q[62:0], 1'b0};
                    end
                    r_num <= {r_num[126:0], 1'b0};
                    if (r_i == 7'd127) begin
                        r_state <= S_SQRT;
                        r_i <= '0;
                    end else begin
                        r_i <= r_i + 7'd1;
                    end
                end
                S_SQRT: begin
                    // r_q holds variance on entry; shifted out two bits a cycle
                    if (r_i == 7'd0) begin
                        r_rem <= '0; r_root <= '0;
                        r_sq  <= '0;
                        r_i   <= 7'd1;
                    end else begin
                        if (!w_strial[66]) begin
                            r_rem  <= w_strial[63:0];
                            r_root <= {r_root[62:0], 1'b1};
                        end else begin
                            r_rem  <= {r_rem[61:0], r_q[63:62]};
                            r_root <= {r_root[62:0], 1'b0};
                        end
                        r_q <= {r_q[61:0], 2'b00};
                        r_i <= r_i + 7'd1;
                        if (r_i == 7'd32) begin
                            r_state <= S_SD;
                        end
                    end
                end
                S_SD: begin
                    r_out.std_value <= (r_root > 64'd65535) ? 16'hFFFF : r_root[15:0];
                    r_i <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
